[design/ffca_pkg.sv]
// Package for the first-fit coalescing allocator.
// Holds the heap geometry, the store word layout, status codes and FSM states.
// No dependencies.
package ffca_pkg;

  localparam int HEAP_BYTES   = 65536;
  localparam int HEADER_BYTES = 64;
  localparam int GRANULES     = HEAP_BYTES / 16;
  localparam int GW           = $clog2(GRANULES);
  localparam int FIRST_BYTES  = (HEADER_BYTES + 15) / 16 * 16;
  localparam int FIRST_G      = FIRST_BYTES / 16;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  typedef struct packed {
    logic [GW-1:0] link;
    logic [GW-1:0] size;
  } word_t;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_FSZ   = 9'b000000100,
    S_HEAD  = 9'b000001000,
    S_WALK  = 9'b000010000,
    S_WR0   = 9'b000100000,
    S_WR1   = 9'b001000000,
    S_WR2   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

endpackage

[design/ffca_if.sv]
// Valid/ready channel interfaces for the allocator's request and result sides.
// Depends on nothing.
interface ffca_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] request_bytes;
  logic [15:0] block_offset;
  modport source (output valid, action, request_bytes, block_offset, input ready);
  modport sink (input valid, action, request_bytes, block_offset, output ready);
endinterface

interface ffca_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_offset;
  logic [1:0]  status;
  logic [16:0] free_bytes;
  modport source (output valid, result_offset, status, free_bytes, input ready);
  modport sink (input valid, result_offset, status, free_bytes, output ready);
endinterface

[design/ffca_mem.sv]
// Granule store: one link and one size per 16-byte granule.
// One write port and one read port with registered read data. Uses ffca_pkg.
module ffca_mem
  import ffca_pkg::*;
(
  input  logic          clk,
  input  logic          rd_en,
  input  logic [GW-1:0] rd_addr,
  output word_t         rd_data,
  input  logic          wr_en,
  input  logic [GW-1:0] wr_addr,
  input  word_t         wr_data
);

  word_t mem [GRANULES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/first_fit_coalescing_allocator.sv]
// First-fit, address-ordered, coalescing heap allocator over 16-byte granules.
// Requests arrive on in_ch: action 0 allocates request_bytes, action 1 frees
// block_offset. Each request gives exactly one transfer on out_ch carrying the
// usable offset, a status (ok, no room, illegal free) and the free byte count.
// The free list lives in a 4096-entry granule store with registered reads; a
// request walks the list one node per cycle from the tail block.
// One request is handled at a time; in_ch is ready only when the block is idle.
// After reset a clearing pass over all 4096 granules zeroes the store and plants
// the single free block; in_ch.ready stays low until it ends.
// A finished result waits in the out_ch register; while it is stalled the next
// request can still be taken and worked on up to its own result.
// Uses ffca_pkg, ffca_in_if, ffca_out_if and ffca_mem.
module first_fit_coalescing_allocator
  import ffca_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ffca_in_if.sink    in_ch,
  ffca_out_if.source out_ch
);

  state_t        state_r, state_nxt;
  logic [GW-1:0] clr_r, clr_nxt;
  logic [GW-1:0] tail_r, tail_nxt;
  logic [16:0]   bytes_r, bytes_nxt;
  logic          is_free_r, is_free_nxt;
  logic [GW:0]   rz_r, rz_nxt;
  logic [GW-1:0] pb_r, pb_nxt;
  logic [GW-1:0] psz_r, psz_nxt;
  logic [GW-1:0] prv_r, prv_nxt;
  logic [GW-1:0] prv_size_r, prv_size_nxt;
  logic [GW-1:0] cur_r, cur_nxt;
  logic [GW:0]   n_r, n_nxt;
  logic [GW-1:0] wa_r [3];
  logic [GW-1:0] wa_nxt [3];
  word_t         wd_r [3];
  word_t         wd_nxt [3];
  logic [2:0]    we_r, we_nxt;
  logic [15:0]   res_off_r, res_off_nxt;
  logic [1:0]    res_st_r, res_st_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_off_r, out_off_nxt;
  logic [1:0]    out_st_r, out_st_nxt;
  logic [16:0]   out_free_r, out_free_nxt;

  logic          rd_en, wr_en;
  logic [GW-1:0] rd_addr, wr_addr;
  word_t         rd_data, wr_data;

  logic [GW-1:0] cs, cl, nw;
  logic          at_tail, in_acc;
  logic [GW:0]   pe, prv_end, lim;
  logic [16:0]   rz_wide;

  ffca_mem u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_ch.ready          = (state_r == S_IDLE);
  assign in_acc               = in_ch.valid && in_ch.ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_offset = out_off_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.free_bytes    = out_free_r;

  assign cs      = rd_data.size;
  assign cl      = rd_data.link;
  assign at_tail = (cur_r == tail_r);
  assign nw      = cur_r + rz_r[GW-1:0];
  assign pe      = {1'b0, pb_r} + {1'b0, psz_r};
  assign prv_end = {1'b0, prv_r} + {1'b0, prv_size_r};
  assign lim     = (GW+1)'(GRANULES);
  assign rz_wide = {1'b0, in_ch.request_bytes} + 17'd23;

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    tail_nxt     = tail_r;
    bytes_nxt    = bytes_r;
    is_free_nxt  = is_free_r;
    rz_nxt       = rz_r;
    pb_nxt       = pb_r;
    psz_nxt      = psz_r;
    prv_nxt      = prv_r;
    prv_size_nxt = prv_size_r;
    cur_nxt      = cur_r;
    n_nxt        = n_r;
    wa_nxt       = wa_r;
    wd_nxt       = wd_r;
    we_nxt       = we_r;
    res_off_nxt  = res_off_r;
    res_st_nxt   = res_st_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_off_nxt  = out_off_r;
    out_st_nxt   = out_st_r;
    out_free_nxt = out_free_r;
    rd_en        = 1'b0;
    rd_addr      = tail_r;
    wr_en        = 1'b0;
    wr_addr      = clr_r;
    wr_data      = '0;

    case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        if (clr_r == GW'(FIRST_G)) begin
          wr_data.link = GW'(FIRST_G);
          wr_data.size = GW'(GRANULES - FIRST_G);
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == GW'(GRANULES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          is_free_nxt = (in_ch.action == ACT_FREE);
          rz_nxt      = rz_wide[16:4];
          pb_nxt      = in_ch.block_offset[15:4];
          res_off_nxt = '0;
          we_nxt      = '0;
          if (in_ch.action == ACT_ALLOC) begin
            rd_en     = 1'b1;
            rd_addr   = tail_r;
            state_nxt = S_HEAD;
          end else if (in_ch.block_offset[3:0] == 4'h8 &&
                       in_ch.block_offset >= 16'(FIRST_BYTES + 8)) begin
            rd_en     = 1'b1;
            rd_addr   = in_ch.block_offset[15:4];
            state_nxt = S_FSZ;
          end else begin
            res_st_nxt = ST_ILLEGAL;
            state_nxt  = S_DONE;
          end
        end
      end
      S_FSZ: begin
        psz_nxt = cs;
        if (cs == '0 || ({1'b0, pb_r} + {1'b0, cs}) > lim) begin
          res_st_nxt = ST_ILLEGAL;
          state_nxt  = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = tail_r;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        prv_nxt      = tail_r;
        prv_size_nxt = cs;
        cur_nxt      = cl;
        n_nxt        = '0;
        rd_en        = 1'b1;
        rd_addr      = cl;
        state_nxt    = S_WALK;
      end
      S_WALK: begin
        if (!is_free_r) begin
          if ({1'b0, cs} < rz_r && !at_tail && n_r < lim) begin
            prv_nxt = cur_r; prv_size_nxt = cs; cur_nxt = cl; n_nxt = n_r + 1'b1;
            rd_en = 1'b1; rd_addr = cl;
          end else if (at_tail ? ({1'b0, cs} < rz_r + 1'b1) : ({1'b0, cs} < rz_r)) begin
            res_st_nxt = ST_NO_ROOM;
            state_nxt  = S_DONE;
          end else begin
            res_st_nxt  = ST_OK;
            res_off_nxt = {cur_r, 4'h8};
            state_nxt   = S_WR0;
            if ({1'b0, cs} < rz_r + 1'b1) begin
              we_nxt    = 3'b011;
              wa_nxt[0] = prv_r;
              wd_nxt[0] = '{link: cl, size: prv_size_r};
              wa_nxt[1] = cur_r;
              wd_nxt[1] = '{link: cl, size: cs};
              bytes_nxt = bytes_r - {1'b0, cs, 4'h0};
            end else begin
              we_nxt    = (prv_r != cur_r) ? 3'b111 : 3'b101;
              wa_nxt[0] = nw;
              wd_nxt[0] = '{link: (prv_r != cur_r) ? cl : nw, size: cs - rz_r[GW-1:0]};
              wa_nxt[1] = prv_r;
              wd_nxt[1] = '{link: nw, size: prv_size_r};
              wa_nxt[2] = cur_r;
              wd_nxt[2] = '{link: cl, size: rz_r[GW-1:0]};
              if (prv_r == cur_r || at_tail) begin
                tail_nxt = nw;
              end
              bytes_nxt = bytes_r - {rz_r, 4'h0};
            end
          end
        end else begin
          if (cur_r < pb_r && !at_tail && n_r < lim) begin
            prv_nxt = cur_r; prv_size_nxt = cs; cur_nxt = cl; n_nxt = n_r + 1'b1;
            rd_en = 1'b1; rd_addr = cl;
          end else if (cur_r <= pb_r || pe > {1'b0, cur_r} ||
                       (prv_r < pb_r && prv_size_r > pb_r - prv_r)) begin
            res_st_nxt = ST_ILLEGAL;
            state_nxt  = S_DONE;
          end else begin
            res_st_nxt = ST_OK;
            state_nxt  = S_WR0;
            bytes_nxt  = bytes_r + {1'b0, psz_r, 4'h0};
            if (prv_r < pb_r && prv_end == {1'b0, pb_r}) begin
              we_nxt    = 3'b001;
              wa_nxt[0] = prv_r;
              if (pe == {1'b0, cur_r}) begin
                wd_nxt[0] = '{link: cl, size: prv_size_r + psz_r + cs};
                if (at_tail) begin
                  tail_nxt = prv_r;
                end
              end else begin
                wd_nxt[0] = '{link: cur_r, size: prv_size_r + psz_r};
              end
            end else if (pe == {1'b0, cur_r}) begin
              wa_nxt[0] = pb_r;
              wa_nxt[1] = prv_r;
              wd_nxt[1] = '{link: pb_r, size: prv_size_r};
              if (cl == cur_r) begin
                we_nxt    = 3'b001;
                wd_nxt[0] = '{link: pb_r, size: psz_r + cs};
                tail_nxt  = pb_r;
              end else begin
                we_nxt    = 3'b011;
                wd_nxt[0] = '{link: cl, size: psz_r + cs};
                if (at_tail) begin
                  tail_nxt = pb_r;
                end
              end
            end else begin
              we_nxt    = 3'b011;
              wa_nxt[0] = pb_r;
              wd_nxt[0] = '{link: cur_r, size: psz_r};
              wa_nxt[1] = prv_r;
              wd_nxt[1] = '{link: pb_r, size: prv_size_r};
            end
          end
        end
      end
      S_WR0: begin
        wr_en = we_r[0]; wr_addr = wa_r[0]; wr_data = wd_r[0];
        state_nxt = S_WR1;
      end
      S_WR1: begin
        wr_en = we_r[1]; wr_addr = wa_r[1]; wr_data = wd_r[1];
        state_nxt = S_WR2;
      end
      S_WR2: begin
        wr_en = we_r[2]; wr_addr = wa_r[2]; wr_data = wd_r[2];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_off_nxt   = res_off_r;
          out_st_nxt    = res_st_r;
          out_free_nxt  = bytes_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      tail_r      <= GW'(FIRST_G);
      bytes_r     <= 17'(HEAP_BYTES - FIRST_BYTES);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      tail_r      <= tail_nxt;
      bytes_r     <= bytes_nxt;
      out_valid_r <= out_valid_nxt;
    end
    is_free_r  <= is_free_nxt;
    rz_r       <= rz_nxt;
    pb_r       <= pb_nxt;
    psz_r      <= psz_nxt;
    prv_r      <= prv_nxt;
    prv_size_r <= prv_size_nxt;
    cur_r      <= cur_nxt;
    n_r        <= n_nxt;
    wa_r       <= wa_nxt;
    wd_r       <= wd_nxt;
    we_r       <= we_nxt;
    res_off_r  <= res_off_nxt;
    res_st_r   <= res_st_nxt;
    out_off_r  <= out_off_nxt;
    out_st_r   <= out_st_nxt;
    out_free_r <= out_free_nxt;
  end

endmodule
